@@ rtl/core/riffw_pkg.sv @@
package riffw_pkg;

	// parser phases
	localparam int PhaseW = 3;
	localparam logic [PhaseW-1:0] PH_HDR  = 3'd0;
	localparam logic [PhaseW-1:0] PH_ID   = 3'd1;
	localparam logic [PhaseW-1:0] PH_LEN  = 3'd2;
	localparam logic [PhaseW-1:0] PH_FMT  = 3'd3;
	localparam logic [PhaseW-1:0] PH_DATA = 3'd4;
	localparam logic [PhaseW-1:0] PH_SKIP = 3'd5;
	localparam logic [PhaseW-1:0] PH_DEAD = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_WAVE  = 3'd1;
	localparam logic [2:0] ST_NOT_PCM   = 3'd2;
	localparam logic [2:0] ST_BAD_CHANS = 3'd3;
	localparam logic [2:0] ST_BAD_BITS  = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;
	localparam logic [2:0] ST_NO_DATA   = 3'd6;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] DEFAULT_RATE = 32'd22050;
	localparam logic [15:0] FLIP_MSB     = 16'h8000;
	localparam logic [30:0] FRAMES_MAX   = 31'h7FFF_FFFF;

	localparam logic [1:0] CH_MONO   = 2'd1;
	localparam logic [1:0] CH_STEREO = 2'd2;
	localparam logic [4:0] BITS_8    = 5'd8;
	localparam logic [4:0] BITS_16   = 5'd16;

	// one buffer byte
	typedef struct packed {
		logic [7:0] data;
		logic       eob;
	} riffw_item_t;

	// one result
	typedef struct packed {
		logic        sample_valid;
		logic [15:0] sample_value;
		logic        done;
		logic [2:0]  status;
		logic [1:0]  channels;
		logic [4:0]  bits;
		logic [31:0] rate;
		logic [30:0] frames;
	} riffw_res_t;

endpackage

@@ rtl/core/riffw_in_stage.sv @@
module riffw_in_stage
	import riffw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  riffw_item_t in_item,
	output logic        in_stall,
	input  logic        step,
	output logic        valid_s1,
	output riffw_item_t item_s1
);

	// holds while the parser cannot consume the registered byte
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ rtl/core/riffw_parse.sv @@
module riffw_parse
	import riffw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  riffw_item_t item_s1,
	output logic        produce,
	output riffw_res_t  res
);

	logic [PhaseW-1:0] phase_q, nx_phase;
	logic [3:0]        idx_q, nx_idx;
	logic [31:0]       tag_q, nx_tag;
	logic [31:0]       left_q, nx_left;
	logic [31:0]       asm_q, nx_asm;
	logic [1:0]        ch_q, nx_ch;
	logic [4:0]        bits_q, nx_bits;
	logic [31:0]       rate_q, nx_rate;
	logic [30:0]       frames_q, nx_frames;
	logic [2:0]        err_q, nx_err;

	logic        smp_valid;
	logic [15:0] smp_value;
	logic [31:0] len;
	logic [31:0] q_ch;
	logic [31:0] q;
	logic [31:0] sbytes;
	logic [31:0] left_dec;
	logic [7:0]  b;
	logic        eob;

	assign b        = item_s1.data;
	assign eob      = item_s1.eob;
	assign left_dec = left_q - 32'd1;
	assign len      = left_q | ({24'b0, b} << {idx_q[1:0], 3'b000});

	// data chunk geometry: frames and sample bytes from the length
	assign q_ch   = (ch_q == CH_STEREO) ? {1'b0, len[31:1]} : len;
	assign q      = (bits_q == BITS_16) ? {1'b0, q_ch[31:1]} : q_ch;
	assign sbytes = (bits_q != BITS_16) ? len :
	                (ch_q == CH_STEREO) ? {len[31:2], 2'b00} : {len[31:1], 1'b0};

	always_comb begin
		nx_phase  = phase_q;
		nx_idx    = idx_q;
		nx_tag    = tag_q;
		nx_left   = left_q;
		nx_asm    = asm_q;
		nx_ch     = ch_q;
		nx_bits   = bits_q;
		nx_rate   = rate_q;
		nx_frames = frames_q;
		nx_err    = err_q;
		smp_valid = 1'b0;
		smp_value = 16'd0;

		case (phase_q)
			PH_HDR: begin
				nx_asm = {asm_q[23:0], b};
				if ((idx_q == 4'd3 && nx_asm != TAG_RIFF) ||
				    (idx_q == 4'd11 && nx_asm != TAG_WAVE)) begin
					nx_err   = ST_NOT_WAVE;
					nx_phase = PH_DEAD;
				end else if (idx_q >= 4'd11) begin
					nx_idx   = 4'd0;
					nx_phase = PH_ID;
				end else begin
					nx_idx = idx_q + 4'd1;
				end
			end
			PH_ID: begin
				nx_tag = {tag_q[23:0], b};
				nx_idx = idx_q + 4'd1;
				if (idx_q >= 4'd3) begin
					nx_idx   = 4'd0;
					nx_left  = 32'd0;
					nx_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				nx_left = len;
				nx_idx  = idx_q + 4'd1;
				if (idx_q >= 4'd3) begin
					if (tag_q == TAG_FMT) begin
						nx_phase = PH_FMT;
						nx_idx   = 4'd0;
						nx_asm   = 32'd0;
					end else if (tag_q == TAG_DATA && q != 32'd0) begin
						nx_frames = q[31] ? FRAMES_MAX : q[30:0];
						nx_left   = sbytes;
						nx_idx    = 4'((len - sbytes) & 32'hF);
						nx_asm    = 32'd0;
						nx_phase  = PH_DATA;
					end else begin
						// empty data chunk, or any other chunk: skip it
						if (tag_q == TAG_DATA) begin
							nx_err = ST_NO_DATA;
						end
						nx_idx   = 4'd0;
						nx_phase = (len != 32'd0) ? PH_SKIP : PH_ID;
					end
				end
			end
			PH_FMT: begin
				case (idx_q)
					4'd1, 4'd3, 4'd5, 4'd15: nx_asm = asm_q | {16'b0, b, 8'b0};
					4'd6:                    nx_asm = asm_q | {8'b0, b, 16'b0};
					4'd7:                    nx_asm = asm_q | {b, 24'b0};
					default:                 nx_asm = {24'b0, b};
				endcase
				nx_idx = idx_q + 4'd1;
				if (idx_q == 4'd1 && nx_asm != 32'd1) begin
					nx_err   = ST_NOT_PCM;
					nx_phase = PH_DEAD;
					nx_idx   = idx_q;
				end else if (idx_q == 4'd3) begin
					if (nx_asm != 32'd1 && nx_asm != 32'd2) begin
						nx_err   = ST_BAD_CHANS;
						nx_phase = PH_DEAD;
						nx_idx   = idx_q;
					end else begin
						nx_ch = nx_asm[1:0];
					end
				end else if (idx_q == 4'd7) begin
					nx_rate = nx_asm;
				end else if (idx_q == 4'd15) begin
					if (nx_asm != 32'd8 && nx_asm != 32'd16) begin
						nx_err   = ST_BAD_BITS;
						nx_phase = PH_DEAD;
						nx_idx   = idx_q;
					end else begin
						// fmt body is 16 bytes, skip any extension
						nx_bits  = nx_asm[4:0];
						nx_left  = (left_q > 32'd16) ? left_q - 32'd16 : 32'd0;
						nx_idx   = 4'd0;
						nx_phase = (left_q > 32'd16) ? PH_SKIP : PH_ID;
					end
				end
			end
			PH_DATA: begin
				if (bits_q == BITS_8) begin
					smp_valid = 1'b1;
					smp_value = {8'b0, b};
				end else if (!left_q[0]) begin
					nx_asm = {24'b0, b};
				end else begin
					smp_valid = 1'b1;
					smp_value = {b, asm_q[7:0]} ^ FLIP_MSB;
				end
				nx_left = left_dec;
				if (left_dec == 32'd0) begin
					// idx holds the leftover bytes not forming a whole frame
					nx_err   = ST_OK;
					nx_left  = {28'b0, idx_q};
					nx_idx   = 4'd0;
					nx_phase = (idx_q != 4'd0) ? PH_SKIP : PH_ID;
				end
			end
			PH_SKIP: begin
				nx_left = left_dec;
				if (left_dec == 32'd0) begin
					nx_idx   = 4'd0;
					nx_phase = PH_ID;
				end
			end
			default: begin
			end
		endcase

		if (eob) begin
			case (nx_phase)
				PH_HDR:  nx_err = ST_NOT_WAVE;
				PH_FMT:  nx_err = (nx_idx < 4'd2) ? ST_NOT_PCM :
				                  (nx_idx < 4'd4) ? ST_BAD_CHANS : ST_BAD_BITS;
				PH_DATA: nx_err = ST_TRUNC;
				default: begin
				end
			endcase
		end
	end

	assign produce = smp_valid || eob;

	always_comb begin
		res.sample_valid = smp_valid;
		res.sample_value = smp_value;
		res.done         = eob;
		res.status       = nx_err;
		res.channels     = nx_ch;
		res.bits         = nx_bits;
		res.rate         = nx_rate;
		res.frames       = nx_frames;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			idx_q    <= 4'd0;
			tag_q    <= 32'd0;
			left_q   <= 32'd0;
			asm_q    <= 32'd0;
			ch_q     <= CH_MONO;
			bits_q   <= BITS_8;
			rate_q   <= DEFAULT_RATE;
			frames_q <= 31'd0;
			err_q    <= ST_NO_DATA;
		end else if (step) begin
			if (eob) begin
				// end of buffer: next byte opens a fresh buffer
				phase_q  <= PH_HDR;
				idx_q    <= 4'd0;
				tag_q    <= 32'd0;
				left_q   <= 32'd0;
				asm_q    <= 32'd0;
				ch_q     <= CH_MONO;
				bits_q   <= BITS_8;
				rate_q   <= DEFAULT_RATE;
				frames_q <= 31'd0;
				err_q    <= ST_NO_DATA;
			end else begin
				phase_q  <= nx_phase;
				idx_q    <= nx_idx;
				tag_q    <= nx_tag;
				left_q   <= nx_left;
				asm_q    <= nx_asm;
				ch_q     <= nx_ch;
				bits_q   <= nx_bits;
				rate_q   <= nx_rate;
				frames_q <= nx_frames;
				err_q    <= nx_err;
			end
		end
	end

	a_eob_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && eob |=> phase_q == PH_HDR && err_q == ST_NO_DATA && idx_q == 4'd0)
		else $error("parser did not restart after end of buffer");

	a_chans_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q == CH_MONO || ch_q == CH_STEREO)
		else $error("latched channel count out of range");

	a_bits_legal: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q == BITS_8 || bits_q == BITS_16)
		else $error("latched sample width out of range");

	a_data_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != 32'd0 && frames_q != 31'd0)
		else $error("data phase with nothing left to emit");

endmodule

@@ rtl/core/riffw_out_stage.sv @@
module riffw_out_stage
	import riffw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  riffw_res_t res,
	input  logic       out_stall,
	output logic       out_free,
	output logic       out_valid,
	output riffw_res_t res_q
);

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result register overwritten while stalled");

endmodule

@@ rtl/core/riff_wave_stream_parser.sv @@
// channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------------
// input    | in_valid / in_stall   | in_byte, end_of_buffer
// output   | out_valid / out_stall | sample_valid, sample_value, done_res, status,
//          |                       | channel_count, bits_per_sample, sample_rate,
//          |                       | frame_count
//
// One byte per cycle while out_stall holds back no result; each result passes the input
// register, then the parse logic into the result register.
// A byte that yields no result never waits on the output side.
// Reset puts the parser at the start of a buffer with the default format (22050 Hz,
// 8 bits, mono); the final byte of each buffer does the same.
// out_stall holds the result register; in_stall rises while a byte waits for that register.
module riff_wave_stream_parser
	import riffw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        sample_valid,
	output logic [15:0] sample_value,
	output logic        done_res,
	output logic [2:0]  status,
	output logic [1:0]  channel_count,
	output logic [4:0]  bits_per_sample,
	output logic [31:0] sample_rate,
	output logic [30:0] frame_count
);

	riffw_item_t in_item, item_s1;
	riffw_res_t  res, res_q;
	logic        valid_s1;
	logic        step;
	logic        produce;
	logic        out_free;

	assign in_item.data = in_byte;
	assign in_item.eob  = end_of_buffer;

	// consume the registered byte unless its result has nowhere to go
	assign step = valid_s1 && (!produce || out_free);

	riffw_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.in_stall (in_stall),
		.step     (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	riffw_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item_s1 (item_s1),
		.produce (produce),
		.res     (res)
	);

	riffw_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && produce),
		.res       (res),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign sample_valid    = res_q.sample_valid;
	assign sample_value    = res_q.sample_value;
	assign done_res        = res_q.done;
	assign status          = res_q.status;
	assign channel_count   = res_q.channels;
	assign bits_per_sample = res_q.bits;
	assign sample_rate     = res_q.rate;
	assign frame_count     = res_q.frames;

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

	a_step_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_free |-> !in_stall)
		else $error("input stalled although result register is free");

	a_done_eob: assert property (@(posedge clk) disable iff (!arst_n)
		step && produce && item_s1.eob |=> out_valid && done_res)
		else $error("end of buffer produced no done result");

endmodule

@@ bench/tb_riff_wave_stream_parser.sv @@
module tb_riff_wave_stream_parser;
	import riffw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [15:0] FMT_TAG_PCM = 16'd1;
	localparam int          DRAIN_CYCLES = 10;
	localparam int          TARGET_BYTES = 1600;

	// Tracks parser state for every byte taken and queues the results it must produce.
	class wave_checker;
		riffw_res_t  pending_results[$];
		int          mismatches;
		logic [2:0]  phase;
		logic [3:0]  pos;
		logic [31:0] chunk_id;
		logic [31:0] remaining;
		logic [31:0] accum;
		logic [1:0]  chans;
		logic [4:0]  width;
		logic [31:0] rate;
		logic [30:0] frames;
		logic [2:0]  code;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			phase     = PH_HDR;
			pos       = '0;
			chunk_id  = '0;
			remaining = '0;
			accum     = '0;
			chans     = CH_MONO;
			width     = BITS_8;
			rate      = DEFAULT_RATE;
			frames    = '0;
			code      = ST_NO_DATA;
		endfunction

		function void next_chunk(logic [31:0] left);
			remaining = left;
			pos       = '0;
			phase     = (left != 0) ? PH_SKIP : PH_ID;
		endfunction

		function int expected_count();
			return pending_results.size();
		endfunction

		function void note_byte(logic [7:0] b, logic eob);
			riffw_res_t  r;
			logic        emit;
			logic [15:0] sval;
			logic [31:0] len, ch, q, sbytes;
			logic [3:0]  fpos;
			emit = 1'b0;
			sval = '0;
			case (phase)
				PH_HDR: begin
					accum = {accum[23:0], b};
					if ((pos == 3 && accum != TAG_RIFF) || (pos == 11 && accum != TAG_WAVE)) begin
						code  = ST_NOT_WAVE;
						phase = PH_DEAD;
					end else if (pos >= 11) begin
						pos   = '0;
						phase = PH_ID;
					end else begin
						pos++;
					end
				end
				PH_ID: begin
					chunk_id = {chunk_id[23:0], b};
					pos++;
					if (pos >= 4) begin
						pos       = '0;
						remaining = '0;
						phase     = PH_LEN;
					end
				end
				PH_LEN: begin
					remaining = remaining | (32'(b) << (8 * pos[1:0]));
					pos++;
					if (pos >= 4) begin
						len = remaining;
						if (chunk_id == TAG_FMT) begin
							phase = PH_FMT;
							pos   = '0;
							accum = '0;
						end else if (chunk_id == TAG_DATA) begin
							ch     = (chans == CH_STEREO) ? 32'd2 : 32'd1;
							q      = len / ch;
							sbytes = len;
							if (width == BITS_16) begin
								q      = q / 2;
								sbytes = q * 2 * ch;
							end
							if (q == 0) begin
								code = ST_NO_DATA;
								next_chunk(len);
							end else begin
								frames    = (q > 32'(FRAMES_MAX)) ? FRAMES_MAX : q[30:0];
								remaining = sbytes;
								pos       = 4'(len - sbytes);
								accum     = '0;
								phase     = PH_DATA;
							end
						end else begin
							next_chunk(len);
						end
					end
				end
				PH_FMT: begin
					fpos = pos;
					// byte placement inside the 16-byte fmt body
					case (fpos)
						4'd1, 4'd3, 4'd5, 4'd15: accum = accum | (32'(b) << 8);
						4'd6:                    accum = accum | (32'(b) << 16);
						4'd7:                    accum = accum | (32'(b) << 24);
						default:                 accum = 32'(b);
					endcase
					if (fpos == 1 && accum != 32'(FMT_TAG_PCM)) begin
						code  = ST_NOT_PCM;
						phase = PH_DEAD;
					end else if (fpos == 3 && accum != 32'(CH_MONO) && accum != 32'(CH_STEREO)) begin
						code  = ST_BAD_CHANS;
						phase = PH_DEAD;
					end else if (fpos == 15) begin
						if (accum != 32'(BITS_8) && accum != 32'(BITS_16)) begin
							code  = ST_BAD_BITS;
							phase = PH_DEAD;
						end else begin
							width = accum[4:0];
							next_chunk(remaining > 16 ? remaining - 16 : 32'd0);
						end
					end else begin
						if (fpos == 3)
							chans = accum[1:0];
						if (fpos == 7)
							rate = accum;
						pos = fpos + 4'd1;
					end
				end
				PH_DATA: begin
					if (width == BITS_8) begin
						emit = 1'b1;
						sval = {8'h00, b};
					end else if (!remaining[0]) begin
						accum = 32'(b);
					end else begin
						emit = 1'b1;
						sval = {b, accum[7:0]} ^ FLIP_MSB;
					end
					remaining--;
					if (remaining == 0) begin
						code = ST_OK;
						next_chunk(32'(pos));
					end
				end
				PH_SKIP: begin
					remaining--;
					if (remaining == 0)
						next_chunk(32'd0);
				end
				default: ;
			endcase

			if (eob) begin
				if (phase == PH_HDR)
					code = ST_NOT_WAVE;
				else if (phase == PH_FMT)
					code = (pos < 2) ? ST_NOT_PCM : (pos < 4) ? ST_BAD_CHANS : ST_BAD_BITS;
				else if (phase == PH_DATA)
					code = ST_TRUNC;
			end

			if (emit || eob) begin
				r.sample_valid = emit;
				r.sample_value = sval;
				r.done         = eob;
				r.status       = code;
				r.channels     = chans;
				r.bits         = width;
				r.rate         = rate;
				r.frames       = frames;
				pending_results.insert(pending_results.size(), r);
			end
			if (eob)
				restart();
		endfunction

		task report(string what);
			mismatches++;
			$display("MISMATCH @%0t: %s", $time, what);
		endtask

		task compare(string field, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got 0x%0h want 0x%0h", field, got, want));
		endtask

		task check_result(riffw_res_t got);
			riffw_res_t want;
			if (pending_results.size() == 0) begin
				report("result with nothing outstanding");
				return;
			end
			want = pending_results.pop_front();
			compare("sample_valid", 32'(got.sample_valid), 32'(want.sample_valid));
			compare("sample_value", 32'(got.sample_value), 32'(want.sample_value));
			compare("done_res", 32'(got.done), 32'(want.done));
			compare("status", 32'(got.status), 32'(want.status));
			compare("channel_count", 32'(got.channels), 32'(want.channels));
			compare("bits_per_sample", 32'(got.bits), 32'(want.bits));
			compare("sample_rate", got.rate, want.rate);
			compare("frame_count", 32'(got.frames), 32'(want.frames));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        end_of_buffer;
	logic        out_valid;
	logic        out_stall;
	logic        sample_valid;
	logic [15:0] sample_value;
	logic        done_res;
	logic [2:0]  status;
	logic [1:0]  channel_count;
	logic [4:0]  bits_per_sample;
	logic [31:0] sample_rate;
	logic [30:0] frame_count;

	wave_checker board = new();
	logic [7:0]  wave_bytes[$];
	int          bytes_sent = 0;
	bit          calm_tx = 1'b0;
	bit          calm_rx = 1'b0;
	logic        rx_blocked = 1'b0;

	riff_wave_stream_parser uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.end_of_buffer  (end_of_buffer),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sample_valid   (sample_valid),
		.sample_value   (sample_value),
		.done_res       (done_res),
		.status         (status),
		.channel_count  (channel_count),
		.bits_per_sample(bits_per_sample),
		.sample_rate    (sample_rate),
		.frame_count    (frame_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// wait before the next transaction; calm stretches run back to back
	function automatic int draw_wait(bit calm);
		if (calm)
			return 0;
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 14);
			1:       return $urandom_range(0, 3);
			default: return 0;
		endcase
	endfunction

	function automatic void append_byte(logic [7:0] v);
		wave_bytes = {wave_bytes, v};
	endfunction

	function automatic void push_random(int n);
		repeat (n) append_byte(8'($urandom));
	endfunction

	// chunk IDs go out in text order, most significant byte first
	function automatic void push_tag(logic [31:0] t);
		for (int i = 3; i >= 0; i--)
			append_byte(t[8*i +: 8]);
	endfunction

	function automatic void push_le(logic [31:0] v, int n);
		for (int i = 0; i < n; i++)
			append_byte(v[8*i +: 8]);
	endfunction

	function automatic void push_header();
		push_tag(TAG_RIFF);
		push_le($urandom, 4);
		push_tag(TAG_WAVE);
	endfunction

	function automatic void push_fmt(logic [31:0] len, logic [15:0] fmt_tag, logic [15:0] chn,
			logic [31:0] hz, logic [15:0] nbits);
		push_tag(TAG_FMT);
		push_le(len, 4);
		push_le(32'(fmt_tag), 2);
		push_le(32'(chn), 2);
		push_le(hz, 4);
		push_le($urandom, 4);
		push_le($urandom, 2);
		push_le(32'(nbits), 2);
		if (len > 16 && len < 64)
			push_random(int'(len - 32'd16));
	endfunction

	function automatic void push_data(logic [31:0] len, int nbytes);
		push_tag(TAG_DATA);
		push_le(len, 4);
		push_random(nbytes);
	endfunction

	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		gap = draw_wait(calm_tx);
		if ($urandom_range(0, 63) == 0)
			calm_tx = !calm_tx;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		in_byte       <= b;
		end_of_buffer <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_byte(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_buffer();
		for (int i = 0; i < wave_bytes.size(); i++)
			send_byte(wave_bytes[i], i == wave_bytes.size() - 1);
		wave_bytes.delete();
	endtask

	function automatic logic [15:0] pick_of_two(logic [15:0] a, logic [15:0] b);
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return a;
		if (r < 90)
			return b;
		return 16'($urandom);
	endfunction

	// mostly well-formed files with random content; some noise and broken headers
	task automatic build_random_buffer();
		int          kind, pick, n, idx;
		logic [31:0] flen;
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			push_random($urandom_range(1, 16));
		end else begin
			push_header();
			if (kind == 1) begin
				idx = $urandom_range(0, 11);
				wave_bytes[idx] = wave_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
			end
			repeat ($urandom_range(1, 4)) begin
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					case ($urandom_range(0, 9))
						6, 7:    flen = $urandom_range(17, 24);
						8:       flen = $urandom_range(0, 15);
						9:       flen = $urandom;
						default: flen = 32'd16;
					endcase
					push_fmt(flen,
						($urandom_range(0, 9) == 0) ? 16'($urandom) : FMT_TAG_PCM,
						pick_of_two(16'(CH_MONO), 16'(CH_STEREO)),
						($urandom_range(0, 3) == 0) ? DEFAULT_RATE : $urandom,
						pick_of_two(16'(BITS_8), 16'(BITS_16)));
				end else if (pick < 80) begin
					n = $urandom_range(0, 24);
					push_data(n, n);
				end else if (pick < 90) begin
					n = $urandom_range(0, 8);
					push_tag($urandom);
					push_le(n, 4);
					push_random(n);
				end else if (pick < 95) begin
					// oversized data chunk; the buffer runs out inside it
					push_data($urandom | 32'h8000_0000, $urandom_range(0, 12));
				end else begin
					push_tag($urandom);
					push_le($urandom | 32'h0100_0000, 4);
					push_random($urandom_range(0, 6));
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, wave_bytes.size());
				while (wave_bytes.size() > n)
					void'(wave_bytes.pop_back());
			end
		end
		send_buffer();
	endtask

	initial begin : stimulus
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_byte       = '0;
		end_of_buffer = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// header that is not RIFF
		push_tag(32'h5249_4658);
		send_buffer();
		// buffer of one byte
		append_byte(8'h52);
		send_buffer();
		// no fmt chunk: default 8-bit mono samples
		push_header();
		push_tag(TAG_DATA);
		push_le(32'd3, 4);
		append_byte(8'h00);
		append_byte(8'hFF);
		append_byte(8'h80);
		send_buffer();
		// empty data chunk
		push_header();
		push_data(32'd0, 0);
		send_buffer();
		// 16-bit stereo, word extremes, one leftover byte skipped
		push_header();
		push_fmt(32'd16, FMT_TAG_PCM, 16'(CH_STEREO), 32'd44100, 16'(BITS_16));
		push_tag(TAG_DATA);
		push_le(32'd9, 4);
		push_le(32'hFFFF_0000, 4);
		push_le(32'h7FFF_8000, 4);
		append_byte(8'hAA);
		send_buffer();
		// fmt faults: tag, channels, bits
		push_header();
		push_fmt(32'd16, 16'd3, 16'(CH_MONO), 32'd8000, 16'(BITS_8));
		send_buffer();
		push_header();
		push_fmt(32'd16, FMT_TAG_PCM, 16'd0, 32'd8000, 16'(BITS_8));
		send_buffer();
		push_header();
		push_fmt(32'd16, FMT_TAG_PCM, 16'(CH_MONO), 32'hFFFF_FFFF, 16'd12);
		send_buffer();
		// ends inside the fmt tag
		push_header();
		push_tag(TAG_FMT);
		push_le(32'd16, 4);
		append_byte(8'h01);
		send_buffer();
		// huge data length: frame count saturates, then truncation
		push_header();
		push_data(32'hFFFF_FFFF, 2);
		send_buffer();

		while (bytes_sent < TARGET_BYTES)
			build_random_buffer();
		in_valid <= 1'b0;

		while (board.expected_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : result_sink
		riffw_res_t got;
		int         hold;
		hold      = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.sample_valid = sample_valid;
				got.sample_value = sample_value;
				got.done         = done_res;
				got.status       = status;
				got.channels     = channel_count;
				got.bits         = bits_per_sample;
				got.rate         = sample_rate;
				got.frames       = frame_count;
				board.check_result(got);
				hold = draw_wait(calm_rx);
				if ($urandom_range(0, 49) == 0)
					calm_rx = !calm_rx;
			end
			@(negedge clk);
			out_stall <= rx_blocked || hold != 0;
			if (hold != 0)
				hold--;
		end
	end

	// long output hold-offs while samples are in flight, so the input side backs up
	initial begin : hold_off
		wait (arst_n === 1'b1);
		repeat (4) begin
			repeat ($urandom_range(300, 1200)) @(posedge clk);
			while (board.expected_count() == 0)
				@(posedge clk);
			rx_blocked = 1'b1;
			repeat (60) @(posedge clk);
			rx_blocked = 1'b0;
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ riff_wave_stream_parser.f @@
rtl/core/riffw_pkg.sv
rtl/core/riffw_in_stage.sv
rtl/core/riffw_parse.sv
rtl/core/riffw_out_stage.sv
rtl/core/riff_wave_stream_parser.sv
bench/tb_riff_wave_stream_parser.sv
